[design/ssa_pkg.sv]
// Shared types and constants for the slab slot allocator.
// Used by ssa_div and slab_slot_allocator; depends on nothing.
package ssa_pkg;

	localparam int POOL_PAGES = 16;
	localparam int PAGE_BYTES = 4096;
	localparam int MAX_SLOTS  = 256;
	localparam int PG_W       = 4;
	localparam int SLOT_W     = 8;
	localparam int DIV_W      = 9;
	localparam int CNT_W      = 13;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PAGE  = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [PG_W:0] STACK_EMPTY = 5'd16;

	typedef struct packed {
		logic        command;
		logic [3:0]  page_number;
		logic [11:0] byte_offset;
	} ssa_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  granted_page;
		logic [11:0] granted_offset;
		logic [12:0] slots_in_use;
		logic [12:0] slots_free;
		logic [4:0]  pages_full;
	} ssa_out_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_NDIV  = 10'b0000000010,
		S_SPARE = 10'b0000000100,
		S_TAKE  = 10'b0000001000,
		S_CMD   = 10'b0000010000,
		S_ALLOC = 10'b0000100000,
		S_AUPD  = 10'b0001000000,
		S_RDIV  = 10'b0010000000,
		S_REL   = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} ssa_state_t;

endpackage

[design/ssa_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on ssa_pkg for its width.
module ssa_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ssa_pkg::DIV_W-1:0] dividend,
	input  logic [ssa_pkg::DIV_W-1:0] divisor,
	output logic [ssa_pkg::DIV_W-1:0] quotient,
	output logic                     done
);

	logic [ssa_pkg::DIV_W-1:0] rem_q;
	logic [ssa_pkg::DIV_W-1:0] quo_q;
	logic [ssa_pkg::DIV_W-1:0] div_q;
	logic [3:0]                cnt_q;
	logic                      done_q;
	logic [ssa_pkg::DIV_W:0]   trial;
	logic                      fit;

	assign trial = {rem_q, quo_q[ssa_pkg::DIV_W-1]};
	assign fit   = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 4'(ssa_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 4'd1;
				done_q <= (cnt_q == 4'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? ssa_pkg::DIV_W'(trial - {1'b0, div_q})
				: trial[ssa_pkg::DIV_W-1:0];
			quo_q <= {quo_q[ssa_pkg::DIV_W-2:0], fit};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[design/slab_slot_allocator.sv]
// Slab slot allocator top level: APB registers, sequencer, slot-chain memory.
// Depends on ssa_pkg and ssa_div.
//
// One transfer in, one result out. The port is not ready while an item is
// processed: an allocate from a partial page goes through the command, alloc,
// update and finish states, a release through command, divide, release and
// finish (a 9-step divider turns the offset into a slot index). Taking a
// fresh page writes its whole slot chain, one slot per cycle. The first item
// after reset or a register write also runs the divider for slots per page
// and takes the spare pages one by one. A result waiting in the output
// register blocks only the next completion, not acceptance.
module slab_slot_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssa_pkg::ssa_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ssa_pkg::ssa_out_t out_data
);

	ssa_pkg::ssa_state_t state_q;

	logic [12:0] slot_bytes_q;
	logic [4:0]  spare_q;
	logic        started_q;
	logic [4:0]  stack_top_q;
	logic [4:0]  pages_taken_q;
	logic [12:0] in_use_q;
	logic [4:0]  full_q;
	logic [8:0]  n_q;
	logic [4:0]  want_q;
	logic [8:0]  i_q;
	logic        ret_alloc_q;
	logic [3:0]  cur_q;
	logic [8:0]  idx_q;
	logic [17:0] prod_q;
	logic [1:0]  status_q;
	logic [3:0]  gpage_q;
	ssa_pkg::ssa_in_t item_q;
	logic        out_valid_q;
	ssa_pkg::ssa_out_t out_q;

	logic [8:0] first_q [ssa_pkg::POOL_PAGES];
	logic [8:0] count_q [ssa_pkg::POOL_PAGES];
	logic [4:0] link_q  [ssa_pkg::POOL_PAGES];
	logic [8:0] chain_mem [ssa_pkg::POOL_PAGES * ssa_pkg::MAX_SLOTS];
	logic [8:0] rdata_q;

	logic        cfg_we;
	logic        accept;
	logic [9:0]  size_up;
	logic [8:0]  div_d;
	logic        div_start;
	logic [8:0]  div_dividend;
	logic [8:0]  quotient;
	logic        div_done;
	logic [3:0]  rd_pg;
	logic [8:0]  rd_first;
	logic [8:0]  rd_count;
	logic [4:0]  rd_link;
	logic        mem_we;
	logic [11:0] mem_waddr;
	logic [8:0]  mem_wdata;
	logic [11:0] mem_raddr;
	logic [8:0]  cnt_dec;
	logic        rel_bad;
	logic [13:0] free_total;

	assign cfg_we   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? {27'd0, spare_q} : {19'd0, slot_bytes_q};
	assign in_ready = (state_q == ssa_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;

	assign size_up = 10'(({1'b0, (slot_bytes_q == 13'd0) ? 13'd1 : slot_bytes_q}
		+ 14'd15) >> 4);
	assign div_d   = (size_up > 10'd256) ? 9'd256 : size_up[8:0];

	assign div_start    = (accept && !started_q)
		|| (state_q == ssa_pkg::S_CMD && item_q.command == ssa_pkg::CMD_RELEASE);
	assign div_dividend = (state_q == ssa_pkg::S_IDLE) ? 9'd256
		: {1'b0, item_q.byte_offset[11:4]};

	ssa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_d),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		case (state_q)
			ssa_pkg::S_AUPD: rd_pg = cur_q;
			ssa_pkg::S_REL:  rd_pg = item_q.page_number;
			default:         rd_pg = stack_top_q[3:0];
		endcase
	end

	assign rd_first = first_q[rd_pg];
	assign rd_count = count_q[rd_pg];
	assign rd_link  = link_q[rd_pg];
	assign cnt_dec  = (rd_count != 9'd0) ? rd_count - 9'd1 : 9'd0;
	assign rel_bad  = ({1'b0, item_q.page_number} >= pages_taken_q)
		|| (quotient >= n_q) || (rd_count >= n_q);

	assign mem_raddr = {stack_top_q[3:0], rd_first[7:0]};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {pages_taken_q[3:0], i_q[7:0]};
		mem_wdata = 9'(i_q + 9'd1);
		if (state_q == ssa_pkg::S_TAKE) begin
			mem_we = 1'b1;
		end else if (state_q == ssa_pkg::S_REL && !rel_bad) begin
			mem_we    = 1'b1;
			mem_waddr = {item_q.page_number, quotient[7:0]};
			mem_wdata = rd_first;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			chain_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= chain_mem[mem_raddr];
	end

	assign free_total = ({9'd0, pages_taken_q} * {5'd0, n_q}) - {1'b0, in_use_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ssa_pkg::S_IDLE;
			slot_bytes_q  <= 13'd16;
			spare_q       <= 5'd1;
			started_q     <= 1'b0;
			stack_top_q   <= ssa_pkg::STACK_EMPTY;
			pages_taken_q <= '0;
			in_use_q      <= '0;
			full_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (paddr[2]) begin
					spare_q <= pwdata[4:0];
				end else begin
					slot_bytes_q <= pwdata[12:0];
				end
				started_q     <= 1'b0;
				stack_top_q   <= ssa_pkg::STACK_EMPTY;
				pages_taken_q <= '0;
				in_use_q      <= '0;
				full_q        <= '0;
			end
			case (state_q)
				ssa_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= started_q ? ssa_pkg::S_CMD : ssa_pkg::S_NDIV;
					end
				end
				ssa_pkg::S_NDIV: begin
					if (div_done) begin
						started_q <= 1'b1;
						state_q   <= ssa_pkg::S_SPARE;
					end
				end
				ssa_pkg::S_SPARE: begin
					if (want_q == '0) begin
						state_q <= ssa_pkg::S_CMD;
					end else if (!pages_taken_q[4]) begin
						state_q <= ssa_pkg::S_TAKE;
					end
				end
				ssa_pkg::S_TAKE: begin
					if (i_q == n_q - 9'd1) begin
						stack_top_q   <= pages_taken_q;
						pages_taken_q <= pages_taken_q + 5'd1;
						state_q <= ret_alloc_q ? ssa_pkg::S_ALLOC : ssa_pkg::S_SPARE;
					end
				end
				ssa_pkg::S_CMD: begin
					if (item_q.command == ssa_pkg::CMD_RELEASE) begin
						state_q <= ssa_pkg::S_RDIV;
					end else if (!stack_top_q[4]) begin
						state_q <= ssa_pkg::S_ALLOC;
					end else if (pages_taken_q[4]) begin
						state_q <= ssa_pkg::S_FIN;
					end else begin
						state_q <= ssa_pkg::S_TAKE;
					end
				end
				ssa_pkg::S_ALLOC: begin
					state_q <= ssa_pkg::S_AUPD;
				end
				ssa_pkg::S_AUPD: begin
					if (rdata_q >= n_q || cnt_dec == 9'd0) begin
						stack_top_q <= rd_link;
						full_q      <= full_q + 5'd1;
					end
					in_use_q <= in_use_q + 13'd1;
					state_q  <= ssa_pkg::S_FIN;
				end
				ssa_pkg::S_RDIV: begin
					if (div_done) begin
						state_q <= ssa_pkg::S_REL;
					end
				end
				ssa_pkg::S_REL: begin
					if (!rel_bad) begin
						if (in_use_q != '0) begin
							in_use_q <= in_use_q - 13'd1;
						end
						if (rd_count == 9'd0) begin
							if (full_q != '0) begin
								full_q <= full_q - 5'd1;
							end
							stack_top_q <= {1'b0, item_q.page_number};
						end
					end
					state_q <= ssa_pkg::S_FIN;
				end
				ssa_pkg::S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ssa_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= ssa_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ssa_pkg::S_IDLE: begin
				if (accept) begin
					item_q   <= in_data;
					status_q <= ssa_pkg::ST_OK;
					gpage_q  <= '0;
					prod_q   <= '0;
					want_q   <= (spare_q > 5'd16) ? 5'd16 : spare_q;
				end
			end
			ssa_pkg::S_NDIV: begin
				n_q <= quotient;
			end
			ssa_pkg::S_SPARE: begin
				if (want_q != '0) begin
					want_q      <= want_q - 5'd1;
					i_q         <= '0;
					ret_alloc_q <= 1'b0;
				end
			end
			ssa_pkg::S_TAKE: begin
				i_q <= i_q + 9'd1;
				if (i_q == n_q - 9'd1) begin
					first_q[pages_taken_q[3:0]] <= '0;
					count_q[pages_taken_q[3:0]] <= n_q;
					link_q[pages_taken_q[3:0]]  <= stack_top_q;
				end
			end
			ssa_pkg::S_CMD: begin
				i_q         <= '0;
				ret_alloc_q <= 1'b1;
				if (item_q.command == ssa_pkg::CMD_ALLOC && stack_top_q[4]
					&& pages_taken_q[4]) begin
					status_q <= ssa_pkg::ST_NO_PAGE;
				end
			end
			ssa_pkg::S_ALLOC: begin
				cur_q <= stack_top_q[3:0];
				idx_q <= rd_first;
			end
			ssa_pkg::S_AUPD: begin
				first_q[cur_q] <= rdata_q;
				count_q[cur_q] <= cnt_dec;
				gpage_q        <= cur_q;
				prod_q         <= {9'd0, idx_q} * {9'd0, div_d};
			end
			ssa_pkg::S_REL: begin
				if (rel_bad) begin
					status_q <= ssa_pkg::ST_BAD_ADDR;
				end else begin
					first_q[item_q.page_number] <= quotient;
					count_q[item_q.page_number] <= rd_count + 9'd1;
					if (rd_count == 9'd0) begin
						link_q[item_q.page_number] <= stack_top_q;
					end
				end
			end
			ssa_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_q.status         <= status_q;
					out_q.granted_page   <= gpage_q;
					out_q.granted_offset <= {prod_q[7:0], 4'd0};
					out_q.slots_in_use   <= in_use_q;
					out_q.slots_free     <= free_total[12:0];
					out_q.pages_full     <= full_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
